[rtl/ttyope_pkg.sv]
// Shared types and constants for the terminal output post-process and echo block.
`default_nettype none
package ttyope_pkg;
    localparam int TAB_SPACES = 8;
    localparam int MAX_RUN    = (TAB_SPACES > 4) ? TAB_SPACES : 4;
    localparam int CNT_W      = $clog2(MAX_RUN + 1);
    localparam int COL_W      = 16;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CARET_OFS = 8'h40;

    localparam logic [4:0] OFLAGS_RESET = 5'd3;
    localparam logic [3:0] EFLAGS_RESET = 4'd5;

    typedef enum logic [1:0] {
        CFG_OUTPUT_FLAGS = 2'd0,
        CFG_ECHO_FLAGS   = 2'd1,
        CFG_EOL_CHAR     = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_ECHO  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             spaces;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [COL_W-1:0] col;
    } t_job;

    function automatic logic [COL_W-1:0] sat_add(input logic [COL_W-1:0] col,
                                                 input logic [CNT_W-1:0] n);
        logic [COL_W:0] s;
        s = {1'b0, col} + (COL_W + 1)'(n);
        return s[COL_W] ? {COL_W{1'b1}} : s[COL_W-1:0];
    endfunction

    function automatic logic printable(input logic [7:0] c);
        return (c >= CH_SPACE) && (c < CH_DEL);
    endfunction
endpackage
`default_nettype wire

[rtl/ttyope_front.sv]
// Front end: configuration registers, column tracking and item classification.
`default_nettype none
module ttyope_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [7:0]            i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_cmd,
    input  wire logic [7:0]            i_ch,
    input  wire logic                  i_quote,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output ttyope_pkg::t_job           o_job
);
    import ttyope_pkg::*;

    logic [4:0]       r_oflags;
    logic [3:0]       r_eflags;
    logic [7:0]       r_eol;
    logic [COL_W-1:0] r_col, n_col;
    logic             accept, emit;
    t_job             job;
    t_cfg_idx         cfg_idx;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign accept      = i_in_valid && !i_q_full;
    assign cfg_idx     = t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oflags <= OFLAGS_RESET;
            r_eflags <= EFLAGS_RESET;
            r_eol    <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (cfg_idx)
                CFG_OUTPUT_FLAGS: r_oflags <= i_cfg_data[4:0];
                CFG_ECHO_FLAGS:   r_eflags <= i_cfg_data[3:0];
                CFG_EOL_CHAR:     r_eol    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (accept) begin
            r_col <= n_col;
        end
    end

    always_comb begin
        logic post, echo_on, ctl_direct, ctl_caret, do_post;
        post       = r_oflags[0];
        echo_on    = r_eflags[0] || (r_eflags[1] && i_ch == CH_NL && !i_quote);
        ctl_direct = !i_quote && (i_ch == CH_TAB || i_ch == CH_NL ||
                                  i_ch == CH_CR || i_ch == CH_BS);
        ctl_caret  = (i_ch == CH_DEL) ||
                     (i_ch < CH_SPACE && (i_quote || (i_ch != CH_TAB && i_ch != CH_NL)));
        do_post   = 1'b0;
        emit       = 1'b1;
        job.cnt    = CNT_W'(1);
        job.spaces = 1'b0;
        job.b0     = i_ch;
        job.b1     = CH_NL;
        n_col      = r_col;

        if (t_cmd'(i_cmd) == CMD_WRITE) begin
            if (post) begin
                do_post = 1'b1;
            end else begin
                if (i_ch == CH_NL || i_ch == CH_CR) begin
                    n_col = '0;
                end else if (i_ch == CH_TAB) begin
                    n_col = sat_add(r_col, CNT_W'(TAB_SPACES));
                end else if (printable(i_ch)) begin
                    n_col = sat_add(r_col, CNT_W'(1));
                end
            end
        end else begin
            if (!echo_on || r_eflags[3]) begin
                emit = 1'b0;
            end else if (post && ctl_direct) begin
                do_post = 1'b1;
            end else if (r_eflags[2] && ctl_caret) begin
                job.b0  = CH_CARET;
                job.b1  = (i_ch == CH_DEL) ? CH_QMARK : i_ch + CARET_OFS;
                job.cnt = (!i_quote && r_eol != 8'd0 && i_ch == r_eol) ?
                          CNT_W'(4) : CNT_W'(2);
                n_col   = sat_add(r_col, CNT_W'(2));
            end else if (printable(i_ch)) begin
                n_col = sat_add(r_col, CNT_W'(1));
            end
        end

        if (do_post) begin
            if (i_ch == CH_TAB) begin
                job.spaces = 1'b1;
                job.cnt    = CNT_W'(TAB_SPACES);
                n_col      = sat_add(r_col, CNT_W'(TAB_SPACES));
            end else if (i_ch == CH_NL) begin
                if (r_oflags[1]) begin
                    job.cnt = CNT_W'(2);
                    job.b0  = CH_CR;
                end
                if (r_oflags[1] || r_oflags[2]) begin
                    n_col = '0;
                end
            end else if (i_ch == CH_CR) begin
                if (r_oflags[4] && r_col == '0) begin
                    emit = 1'b0;
                end else if (r_oflags[3]) begin
                    job.b0 = CH_NL;
                end else begin
                    n_col = '0;
                end
            end else if (printable(i_ch)) begin
                n_col = sat_add(r_col, CNT_W'(1));
            end
        end
        job.col = n_col;
    end

    assign o_push = accept && emit;
    assign o_job  = job;
endmodule
`default_nettype wire

[rtl/ttyope_queue.sv]
// Two-entry job queue between the front end and the byte emitter.
`default_nettype none
module ttyope_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ttyope_pkg::t_job  i_job,
    output logic                   o_full,
    output logic                   o_valid,
    output ttyope_pkg::t_job       o_job,
    input  wire logic              i_pop
);
    import ttyope_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(do_pop);
        end
    end
endmodule
`default_nettype wire

[rtl/ttyope_back.sv]
// Back end: expands the head job into output bytes, one beat per cycle unless stalled.
`default_nettype none
module ttyope_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire ttyope_pkg::t_job  i_job,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [7:0]             o_out_char,
    output logic                   o_last_of_run,
    output logic [15:0]            o_column_after
);
    import ttyope_pkg::*;

    logic [CNT_W-1:0] r_idx;
    logic             beat, last;

    assign o_out_valid    = i_valid;
    assign beat           = i_valid && !i_out_stall;
    assign last           = (r_idx == i_job.cnt - CNT_W'(1));
    assign o_pop          = beat && last;
    assign o_last_of_run  = last;
    assign o_column_after = i_job.col;

    always_comb begin
        if (i_job.spaces) begin
            o_out_char = CH_SPACE;
        end else if (r_idx == '0) begin
            o_out_char = i_job.b0;
        end else if (r_idx == CNT_W'(1)) begin
            o_out_char = i_job.b1;
        end else begin
            o_out_char = CH_BS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (beat) begin
            r_idx <= last ? '0 : r_idx + CNT_W'(1);
        end
    end
endmodule
`default_nettype wire

[rtl/tty_output_postprocess_echo.sv]
// Top level of the terminal output post-process and echo block.
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one character per beat: i_cmd selects
//   write or echo, i_ch is the byte, i_quote marks a quoted echo character.
//   Output channel (o_out_valid / i_out_stall) gives one output byte per beat, with
//   o_last_of_run on the final byte of a character and o_column_after the column
//   once that character is done.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes output flags (index 0),
//   echo flags (index 1) and the extra end of line character (index 2); always ready.
// Timing:
//   First byte of a character is valid the cycle after it is accepted, if the queue was empty.
//   The front end takes one character per cycle while the two-entry job queue has room.
//   The emitter sends one byte per cycle while i_out_stall is low; a character gives
//   1 byte for most, 2 for CR LF and caret echo, 4 for caret echo of the end of
//   line character, TAB_SPACES for an expanded tab; none when suppressed.
// Reset: synchronous, active low; clears the queue and column, loads default flags.
// When i_out_stall is high the current byte holds; the queue fills and then
// o_in_stall rises.
`default_nettype none
module tty_output_postprocess_echo (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_quote,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_char,
    output logic             o_last_of_run,
    output logic [15:0]      o_column_after
);
    import ttyope_pkg::*;

    logic q_full, q_push, q_valid, q_pop;
    t_job push_job, head_job;

    ttyope_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_ch        (i_ch),
        .i_quote     (i_quote),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    ttyope_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    ttyope_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_job          (head_job),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_char     (o_out_char),
        .o_last_of_run  (o_last_of_run),
        .o_column_after (o_column_after)
    );
endmodule
`default_nettype wire

[rtl/ttyope_checker.sv]
// Port-level assertions for the top level, bound in below.
`default_nettype none
module ttyope_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [7:0]  o_out_char,
    input wire logic        o_last_of_run,
    input wire logic [15:0] o_column_after
);
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_run |=>
        o_out_valid && o_column_after == $past(o_column_after))
        else $error("run broken or column changed inside a run");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
        o_out_valid && $stable(o_out_char) && $stable(o_last_of_run))
        else $error("stalled output beat changed");
endmodule

bind tty_output_postprocess_echo ttyope_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_char     (o_out_char),
    .o_last_of_run  (o_last_of_run),
    .o_column_after (o_column_after)
);
`default_nettype wire
